FILE: rtl/atr_pkg.sv
// Shared types, op codes and constants for the alarm time entry and ring block.
// Holds the character field parser used by the entry checker.
// No dependencies.
package atr_pkg;

	localparam int unsigned ENTRY_DEPTH = 8;
	localparam int unsigned IDX_W       = 3;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned CHAR_W      = 8;

	localparam logic [CNT_W-1:0] ENTRY_FULL = 4'd8;

	// op codes
	localparam logic [2:0] OP_CHAR      = 3'd0;
	localparam logic [2:0] OP_ENTER     = 3'd1;
	localparam logic [2:0] OP_BACKSPACE = 3'd2;
	localparam logic [2:0] OP_NEW_ENTRY = 3'd3;
	localparam logic [2:0] OP_CLR_ACC   = 3'd4;
	localparam logic [2:0] OP_TICK      = 3'd5;

	localparam logic [7:0] RING_LEN_RST = 8'd40;
	localparam logic [4:0] HOURS_RST    = 5'd12;
	localparam logic [5:0] MINUTES_RST  = 6'd12;
	localparam logic [5:0] SECONDS_RST  = 6'd12;

	localparam logic [6:0] HOURS_LIMIT = 7'd24;
	localparam logic [6:0] MS_LIMIT    = 7'd60;

	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

	localparam int unsigned COLON_A = 2;
	localparam int unsigned COLON_B = 5;

	typedef logic [ENTRY_DEPTH-1:0][CHAR_W-1:0] atr_chars_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] char_code;
		logic [4:0] now_hours;
		logic [5:0] now_minutes;
		logic [5:0] now_seconds;
		logic       player_busy;
	} atr_in_t;

	typedef struct packed {
		logic [3:0] entry_length;
		logic       time_accepted;
		logic [4:0] alarm_hours;
		logic [5:0] alarm_minutes;
		logic [5:0] alarm_seconds;
		logic       ringing;
		logic       start_play;
		logic       stop_play;
	} atr_out_t;

	// parsed two-character field
	typedef struct packed {
		logic       ok;
		logic [6:0] val;
	} atr_field_t;

	// verdict of the entry checker
	typedef struct packed {
		logic       ok;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} atr_time_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// leading blank, sign or digit, then up to one more digit; negative nonzero fails
	function automatic atr_field_t parse_field(input logic [CHAR_W-1:0] a,
			input logic [CHAR_W-1:0] b);
		atr_field_t r;
		logic [CHAR_W-1:0] da;
		logic [CHAR_W-1:0] db;
		logic [6:0] vb;
		logic neg;
		da  = a - CH_ZERO;
		db  = b - CH_ZERO;
		vb  = is_digit(b) ? {3'd0, db[3:0]} : 7'd0;
		neg = 1'b0;
		r.val = 7'd0;
		if (is_blank(a)) begin
			r.val = vb;
		end else if ((a == CH_PLUS) || (a == CH_MINUS)) begin
			neg   = (a == CH_MINUS);
			r.val = vb;
		end else if (is_digit(a)) begin
			r.val = is_digit(b) ? ({3'd0, da[3:0]} * 7'd10 + vb) : {3'd0, da[3:0]};
		end
		r.ok = !(neg && (r.val != 7'd0));
		return r;
	endfunction

endpackage

FILE: rtl/atr_entry_check.sv
// Entry checker: decides whether the buffer holds a valid HH:MM:SS time.
// Pure combinational; uses atr_pkg for types and the field parser.
module atr_entry_check (
	input  atr_pkg::atr_chars_t     chars,
	input  logic [3:0]              count,
	output atr_pkg::atr_time_t      verdict
);
	import atr_pkg::*;

	atr_field_t f_h;
	atr_field_t f_m;
	atr_field_t f_s;
	logic       shape_ok;

	assign f_h = parse_field(chars[0], chars[1]);
	assign f_m = parse_field(chars[3], chars[4]);
	assign f_s = parse_field(chars[6], chars[7]);

	assign shape_ok = (count == ENTRY_FULL) && (chars[COLON_A] == CH_COLON)
		&& (chars[COLON_B] == CH_COLON);

	assign verdict.ok = shape_ok
		&& f_h.ok && (f_h.val < HOURS_LIMIT)
		&& f_m.ok && (f_m.val < MS_LIMIT)
		&& f_s.ok && (f_s.val < MS_LIMIT);
	assign verdict.hours   = f_h.val[4:0];
	assign verdict.minutes = f_m.val[5:0];
	assign verdict.seconds = f_s.val[5:0];

endmodule

FILE: rtl/alarm_time_entry_and_ring.sv
// Top level of the alarm time entry and ring block.
// Depends on atr_pkg and atr_entry_check.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_stall  in_data  (atr_in_t)
//   out_*        out  out_valid / out_stall out_data (atr_out_t)
//   cfg_*        in   cfg_wr_en            cfg_wr_data (ring length)
//
// Each request is taken into an input register (_s1); when that stage advances,
// its effect on the entry buffer, stored alarm and ring state is applied while
// the result is loaded into the output register. One request per cycle is
// sustained while out_stall is low. The output register is the only thing that
// can hold the pipe: when it is full and stalled, in_stall rises with a full
// input stage. Reset (arst_n low) empties both stages, sets the alarm to
// 12:12:12, ring length to 40 and clears the entry and ring state.
module alarm_time_entry_and_ring (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  atr_pkg::atr_in_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output atr_pkg::atr_out_t out_data,
	input  logic             cfg_wr_en,
	input  logic [7:0]       cfg_wr_data
);
	import atr_pkg::*;

	// input stage
	logic    valid_s1;
	atr_in_t req_s1;

	// block state
	atr_chars_t entry_q;
	logic [CNT_W-1:0] count_q;
	logic       acc_q;
	logic [4:0] hours_q;
	logic [5:0] minutes_q;
	logic [5:0] seconds_q;
	logic       ring_q;
	logic [7:0] ring_cnt_q;
	logic [7:0] ring_len_q;

	// output register
	logic     out_valid_q;
	atr_out_t out_q;

	// next-state logic
	logic [CNT_W-1:0] count_d;
	logic       acc_d;
	logic [4:0] hours_d;
	logic [5:0] minutes_d;
	logic [5:0] seconds_d;
	logic       ring_d;
	logic [7:0] ring_cnt_d;
	logic       start_d;
	logic       stop_d;
	logic       char_wr;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0] ring_cnt_inc;
	logic       time_match;
	atr_time_t  verdict;

	logic advance;
	logic in_take;

	// the stage moves on whenever the output register is free or drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	atr_entry_check u_check (
		.chars   (entry_q),
		.count   (count_q),
		.verdict (verdict)
	);

	assign ring_cnt_inc = ring_cnt_q + 8'd1;
	assign time_match   = (hours_q == req_s1.now_hours) && (minutes_q == req_s1.now_minutes)
		&& (seconds_q == req_s1.now_seconds);
	// a full buffer wraps back to the first slot
	assign wr_idx = (count_q == ENTRY_FULL) ? '0 : count_q[IDX_W-1:0];

	always_comb begin
		count_d    = count_q;
		acc_d      = acc_q;
		hours_d    = hours_q;
		minutes_d  = minutes_q;
		seconds_d  = seconds_q;
		ring_d     = ring_q;
		ring_cnt_d = ring_cnt_q;
		start_d    = 1'b0;
		stop_d     = 1'b0;
		char_wr    = 1'b0;
		case (req_s1.op)
			OP_CHAR: begin
				char_wr = 1'b1;
				count_d = {1'b0, wr_idx} + 4'd1;
			end
			OP_ENTER: begin
				if (verdict.ok) begin
					acc_d     = 1'b1;
					hours_d   = verdict.hours;
					minutes_d = verdict.minutes;
					seconds_d = verdict.seconds;
				end
			end
			OP_BACKSPACE: begin
				if (count_q != '0) begin
					count_d = count_q - 4'd1;
				end
			end
			OP_NEW_ENTRY: begin
				count_d = '0;
				acc_d   = 1'b0;
			end
			OP_CLR_ACC: begin
				acc_d = 1'b0;
			end
			OP_TICK: begin
				if (ring_q) begin
					// count ring ticks; a zero length wraps after 256
					if (ring_cnt_inc == ring_len_q) begin
						ring_cnt_d = '0;
						ring_d     = 1'b0;
						stop_d     = 1'b1;
					end else begin
						ring_cnt_d = ring_cnt_inc;
					end
				end else if (time_match) begin
					ring_d  = 1'b1;
					start_d = 1'b1;
					if (req_s1.player_busy) begin
						// pre-empt whatever the player is doing
						stop_d     = 1'b1;
						ring_cnt_d = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= in_data;
		end
	end

	// entry characters have no reset; only slots below the count affect the verdict
	always_ff @(posedge clk) begin
		if (advance && char_wr) begin
			entry_q[wr_idx] <= req_s1.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			acc_q      <= 1'b0;
			hours_q    <= HOURS_RST;
			minutes_q  <= MINUTES_RST;
			seconds_q  <= SECONDS_RST;
			ring_q     <= 1'b0;
			ring_cnt_q <= '0;
		end else if (advance) begin
			count_q    <= count_d;
			acc_q      <= acc_d;
			hours_q    <= hours_d;
			minutes_q  <= minutes_d;
			seconds_q  <= seconds_d;
			ring_q     <= ring_d;
			ring_cnt_q <= ring_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_len_q <= RING_LEN_RST;
		end else if (cfg_wr_en) begin
			ring_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.entry_length  <= count_d;
			out_q.time_accepted <= acc_d;
			out_q.alarm_hours   <= hours_d;
			out_q.alarm_minutes <= minutes_d;
			out_q.alarm_seconds <= seconds_d;
			out_q.ringing       <= ring_d;
			out_q.start_play    <= start_d;
			out_q.stop_play     <= stop_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_start_rings: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.start_play) |-> out_data.ringing)
		else $error("start_play without ringing");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.entry_length <= ENTRY_FULL))
		else $error("entry length above buffer depth");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output can drain");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!ring_q |-> (ring_cnt_q == '0))
		else $error("ring counter nonzero while not ringing");

	a_hours_range: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> ({2'b00, hours_q} < HOURS_LIMIT))
		else $error("stored hours out of range");
`endif

endmodule
